// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;
  localparam int OUT_IDX_W  = 8;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_QUERY  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_ANSWERED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_t;

  // A query token as it walks down the chain. The pending fields carry the
  // squared terms of the previous cell, which the next cell adds and compares.
  typedef struct packed {
    logic                  vld;
    logic [COORD_BITS-1:0] qx;
    logic [COORD_BITS-1:0] qy;
    logic                  found;
    logic [DIST_BITS-1:0]  best_d;
    logic [IDX_BITS-1:0]   best_idx;
    logic [COORD_BITS-1:0] best_x;
    logic [COORD_BITS-1:0] best_y;
    logic                  pend_vld;
    logic [SQ_BITS-1:0]    pend_sx;
    logic [SQ_BITS-1:0]    pend_sy;
    logic [IDX_BITS-1:0]   pend_idx;
    logic [COORD_BITS-1:0] pend_x;
    logic [COORD_BITS-1:0] pend_y;
  } tok_t;

  function automatic logic [COORD_BITS-1:0] nps_absdiff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] diff;
    logic [COORD_BITS:0] neg;
    diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    neg  = -diff;
    return diff[COORD_BITS] ? neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
  endfunction

  // Folds the pending candidate into the best so far. A later candidate at
  // equal distance replaces the current best, so the highest index wins ties.
  function automatic tok_t nps_merge(input tok_t t);
    tok_t                 r;
    logic [DIST_BITS-1:0] d;
    r = t;
    d = DIST_BITS'(t.pend_sx) + DIST_BITS'(t.pend_sy);
    if (t.pend_vld && (!t.found || d <= t.best_d)) begin
      r.found    = 1'b1;
      r.best_d   = d;
      r.best_idx = t.pend_idx;
      r.best_x   = t.pend_x;
      r.best_y   = t.pend_y;
    end
    r.pend_vld = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One table entry. Holds a point, merges the upstream candidate into the
// running best and offers its own squared terms to the next cell.
module nps_cell import nps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IDX_BITS-1:0]   cell_idx,
  input  wire logic [CNT_BITS-1:0]   count,
  input  wire logic                  wr_en,
  input  wire logic [COORD_BITS-1:0] wr_x,
  input  wire logic [COORD_BITS-1:0] wr_y,
  input  wire tok_t                  tok_in,
  output tok_t                       tok_out
);

  logic [COORD_BITS-1:0] pt_x_r;
  logic [COORD_BITS-1:0] pt_y_r;
  tok_t                  pay_r;
  tok_t                  pay_nxt;
  logic                  vld_r;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic                  live;

  always_comb begin
    live    = CNT_BITS'(cell_idx) < count;
    ax      = nps_absdiff(tok_in.qx, pt_x_r);
    ay      = nps_absdiff(tok_in.qy, pt_y_r);
    pay_nxt = nps_merge(tok_in);
    pay_nxt.pend_vld = live;
    pay_nxt.pend_sx  = SQ_BITS'(ax) * SQ_BITS'(ax);
    pay_nxt.pend_sy  = SQ_BITS'(ay) * SQ_BITS'(ay);
    pay_nxt.pend_idx = cell_idx;
    pay_nxt.pend_x   = pt_x_r;
    pay_nxt.pend_y   = pt_y_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_x_r <= wr_x;
      pt_y_r <= wr_y;
    end
    pay_r <= pay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_in.vld;
    end
  end

  always_comb begin
    tok_out     = pay_r;
    tok_out.vld = vld_r;
  end

endmodule

`default_nettype wire

// ===== rtl/nearest_point_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest-point search over a table of up to 256 two-dimensional points.
// Input channel (in_valid/in_ready): in_func selects insert or query, and
// in_coord_x/in_coord_y give a signed point. Result channel (out_valid/
// out_ready) returns one item for every input item: a status, the nearest
// stored point and its index.
// An insert writes the next free table entry and returns its index in the cycle
// after acceptance. An insert into a full table is dropped with a full status;
// a query on an empty table returns an empty status, also in the next cycle.
// A query launches a token into a chain of 256 cells, one cell per entry. The
// token moves one cell per cycle to the end of the chain, where its result is
// latched in a holding register, then in the output register. One item is in
// work at a time; the next item is taken once the block is idle and the output
// register is free or being emptied in the same cycle.
// If the receiver stalls, the finished item waits in the output register and
// a query result waits in a holding register behind it; nothing is lost.
// Reset empties the table (the point count returns to zero), clears the valid
// flags of the chain and of the output register. Stored coordinates are not
// cleared; entries at or above the point count never become candidates.
module nearest_point_search import nps_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_func,
  input  wire logic signed [COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic signed [COORD_BITS-1:0]      out_near_x,
  output logic signed [COORD_BITS-1:0]      out_near_y,
  output logic [OUT_IDX_W-1:0]              out_near_index
);

  state_t                st_r, st_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic [OUT_IDX_W-1:0]  out_idx_r, out_idx_nxt;

  logic [COORD_BITS-1:0] hold_x_r, hold_x_nxt;
  logic [COORD_BITS-1:0] hold_y_r, hold_y_nxt;
  logic [IDX_BITS-1:0]   hold_idx_r, hold_idx_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  is_query;
  logic                  tbl_full;
  logic                  tbl_empty;
  logic                  ins_write;

  tok_t                  head_tok;
  tok_t                  chain [MAX_POINTS+1];
  tok_t                  final_tok;
  logic [MAX_POINTS-1:0] chain_vld;

  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = (st_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign is_query  = (in_func == FN_QUERY);
  assign tbl_full  = (cnt_r == CNT_BITS'(MAX_POINTS));
  assign tbl_empty = (cnt_r == '0);
  assign ins_write = in_fire && !is_query && !tbl_full;

  // The query token enters the first cell with no candidate yet.
  always_comb begin
    head_tok     = '0;
    head_tok.vld = in_fire && is_query && !tbl_empty;
    head_tok.qx  = in_coord_x;
    head_tok.qy  = in_coord_y;
  end

  assign chain[0] = head_tok;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    nps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_BITS'(i)),
      .count    (cnt_r),
      .wr_en    (ins_write && (cnt_r == CNT_BITS'(i))),
      .wr_x     (in_coord_x),
      .wr_y     (in_coord_y),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
    assign chain_vld[i] = chain[i+1].vld;
  end

  // The last cell still holds its own candidate as pending; fold it in here.
  assign final_tok = nps_merge(chain[MAX_POINTS]);

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_idx_nxt    = out_idx_r;
    hold_x_nxt     = hold_x_r;
    hold_y_nxt     = hold_y_r;
    hold_idx_nxt   = hold_idx_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_query && !tbl_empty) begin
            st_nxt = S_SCAN;
          end else begin
            out_vld_nxt = 1'b1;
            out_x_nxt   = '0;
            out_y_nxt   = '0;
            out_idx_nxt = '0;
            if (is_query) begin
              out_status_nxt = ST_EMPTY;
            end else if (tbl_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_INSERTED;
              out_idx_nxt    = OUT_IDX_W'(cnt_r);
              cnt_nxt        = cnt_r + CNT_BITS'(1);
            end
          end
        end
      end
      S_SCAN: begin
        if (final_tok.vld) begin
          hold_x_nxt   = final_tok.best_x;
          hold_y_nxt   = final_tok.best_y;
          hold_idx_nxt = final_tok.best_idx;
          st_nxt       = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = ST_ANSWERED;
          out_x_nxt      = hold_x_r;
          out_y_nxt      = hold_y_r;
          out_idx_nxt    = OUT_IDX_W'(hold_idx_r);
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_idx_r    <= out_idx_nxt;
    hold_x_r     <= hold_x_nxt;
    hold_y_r     <= hold_y_nxt;
    hold_idx_r   <= hold_idx_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_near_x     = out_x_r;
  assign out_near_y     = out_y_r;
  assign out_near_index = out_idx_r;

  // At most one query token travels the chain, and only during a scan.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld) && (!(|chain_vld) || st_r == S_SCAN))
    else $error("query token outside a scan or duplicated");

  // A query on an empty table answers in the next cycle with an empty status.
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_query && tbl_empty |=> out_valid && out_status == ST_EMPTY)
    else $error("empty-table query not answered at once");

  // An insert into a full table leaves the count alone and reports full.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_query && tbl_full |=> $stable(cnt_r) && out_status == ST_FULL)
    else $error("insert into full table not dropped");

  // An answered query names a stored entry.
  a_idx_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ANSWERED |-> CNT_BITS'(out_near_index) < cnt_r)
    else $error("answer index beyond stored points");

endmodule

`default_nettype wire
